// File: hdl/volume_blend_factor_top_defines.svh
// Assertion macros for the volume blend factor block.
// Used by the port checker; depends on a clk and rst_n in the including scope.
`ifndef VOLUME_BLEND_FACTOR_TOP_DEFINES_SVH
`define VOLUME_BLEND_FACTOR_TOP_DEFINES_SVH

// Property checked only outside reset.
`define VBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define VBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/vbf_pkg.sv
// Shared constants for the volume blend factor block.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps

package vbf_pkg;

  localparam int COORD_BITS_DEF      = 20;
  localparam int BLEND_FRAC_BITS_DEF = 16;
  localparam int COORD_FRAC          = 8;
  localparam int SQRT_PAD            = 2 * COORD_FRAC;
  localparam int CFG_IDX_W           = 3;

  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;
  localparam logic [1:0] SHAPE_CYL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER  = 3'd5;

endpackage

// File: hdl/vbf_sqrt_cell.sv
// One digit cell of the integer square root chain (two radicand bits per cell).
// No dependencies.
`timescale 1ns / 1ps

module vbf_sqrt_cell #(
  parameter int RAD_W = 58,
  parameter int RT_W  = 29
) (
  input  logic             clk,
  input  logic             en,
  input  logic [RT_W+2:0]  rem_i,
  input  logic [RT_W-1:0]  root_i,
  input  logic [RAD_W-1:0] rad_i,
  output logic [RT_W+2:0]  rem_o,
  output logic [RT_W-1:0]  root_o,
  output logic [RAD_W-1:0] rad_o
);

  localparam int RW = RT_W + 3;

  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             ge;
  logic [RW-1:0]    rem_r;
  logic [RT_W-1:0]  root_r;
  logic [RAD_W-1:0] rad_r;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], rad_i[RAD_W-1 -: 2]};
    trial  = RW'({root_i, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_i[RT_W-2:0], ge};
      rad_r  <= {rad_i[RAD_W-3:0], 2'b00};
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

// File: hdl/vbf_div_cell.sv
// One quotient-bit cell of the restoring divider chain.
// No dependencies.
`timescale 1ns / 1ps

module vbf_div_cell #(
  parameter int W  = 29,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W:0]    rem_i,
  input  logic [W-1:0]  den_i,
  input  logic [QW-1:0] q_i,
  output logic [W:0]    rem_o,
  output logic [W-1:0]  den_o,
  output logic [QW-1:0] q_o
);

  logic          ge;
  logic [W:0]    diff;
  logic [W:0]    rem_r;
  logic [W-1:0]  den_r;
  logic [QW-1:0] q_r;

  always_comb begin
    ge   = (rem_i >= {1'b0, den_i});
    diff = ge ? (rem_i - {1'b0, den_i}) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= {diff[W-1:0], 1'b0};
      den_r <= den_i;
      q_r   <= {q_i[QW-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;

endmodule

// File: hdl/vbf_delay.sv
// Row of delay cells carrying a valid flag and side data beside a chain.
// No dependencies.
`timescale 1ns / 1ps

module vbf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);

  logic [DEPTH-1:0]        vld_r;
  logic [DEPTH-1:0][W-1:0] dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= dat_i;
      for (int k = 1; k < DEPTH; k++) begin
        dat_r[k] <= dat_r[k-1];
      end
    end
  end

  assign vld_o = vld_r[DEPTH-1];
  assign dat_o = dat_r[DEPTH-1];

endmodule

// File: hdl/volume_blend_factor_top.sv
// Volume blend factor: point in sphere / box / cylinder with linear edge falloff.
// Pipeline depth is set by the root chain (COORD_BITS+9 cells) and two divider chains
// (BLEND_FRAC_BITS+1 cells each). Throughput: one request per cycle; the whole pipe
// holds only when a result waits at the output and the last stage is full. Reset
// (rst_n, synchronous) clears the configuration registers and all valid flags.
`timescale 1ns / 1ps

module volume_blend_factor_top #(
  parameter int COORD_BITS      = vbf_pkg::COORD_BITS_DEF,
  parameter int BLEND_FRAC_BITS = vbf_pkg::BLEND_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   in_point_x,
  input  logic signed [COORD_BITS-1:0]   in_point_y,
  input  logic signed [COORD_BITS-1:0]   in_point_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_inside_res,
  output logic [BLEND_FRAC_BITS:0]       out_blend,
  input  logic                           cfg_we,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [3*COORD_BITS-1:0]        cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int QW    = BLEND_FRAC_BITS + 1;
  localparam int SQ_W  = 2 * CB + 2;                  // sum of three squares
  localparam int RAD_W = SQ_W + vbf_pkg::SQRT_PAD;    // radicand, scaled up
  localparam int RT_W  = RAD_W / 2;                   // root width
  localparam int DW    = RT_W;                        // divider operand width
  localparam int NL    = 5;                           // divider lanes
  localparam int L_RAD = 0;
  localparam int L_X   = 1;
  localparam int L_Y   = 2;
  localparam int L_Z   = 3;
  localparam int L_C   = 4;
  localparam logic [QW-1:0] ONE = QW'(1) << BLEND_FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers: user must write only while pipe is empty; unenforced.
  // ---------------------------------------------------------------------------
  logic [1:0]      shape_r;
  logic [3*CB-1:0] center_r;
  logic [CB-1:0]   radius_r;
  logic [3*CB-1:0] ext_r;
  logic [CB-1:0]   height_r;
  logic [CB-1:0]   inner_r;
  logic [2*CB-1:0] rsq_r;    // radius squared, follows radius_r
  logic [CB-1:0]   maxe_r;   // largest box half extent
  logic [CB-1:0]   maxe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= '0;
      center_r <= '0;
      radius_r <= '0;
      ext_r    <= '0;
      height_r <= '0;
      inner_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vbf_pkg::REG_SHAPE:  shape_r  <= cfg_data[1:0];
        vbf_pkg::REG_CENTER: center_r <= cfg_data;
        vbf_pkg::REG_RADIUS: radius_r <= cfg_data[CB-1:0];
        vbf_pkg::REG_EXT:    ext_r    <= cfg_data;
        vbf_pkg::REG_HEIGHT: height_r <= cfg_data[CB-1:0];
        vbf_pkg::REG_INNER:  inner_r  <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    maxe_nxt = ext_r[0 +: CB];
    if (ext_r[CB +: CB] > maxe_nxt) maxe_nxt = ext_r[CB +: CB];
    if (ext_r[2*CB +: CB] > maxe_nxt) maxe_nxt = ext_r[2*CB +: CB];
  end

  // Derived values; refreshed every cycle and settled long before a request
  // reaches the stages that read them.
  always_ff @(posedge clk) begin
    rsq_r  <= (2*CB)'(radius_r) * (2*CB)'(radius_r);
    maxe_r <= maxe_nxt;
  end

  logic is_box;
  logic is_cyl;
  assign is_box = (shape_r == vbf_pkg::SHAPE_BOX);
  assign is_cyl = (shape_r == vbf_pkg::SHAPE_CYL);

  // ---------------------------------------------------------------------------
  // Flow control. Every stage advances together; hold only when the output
  // register is blocked and the last stage has a result to hand over.
  // ---------------------------------------------------------------------------
  logic en;
  logic vld_c;
  logic out_valid_r;
  logic out_valid_nxt;

  assign en       = !(out_valid_r && !out_ready && vld_c);
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: per-axis distance magnitude.
  // ---------------------------------------------------------------------------
  logic [2:0][CB-1:0] pt_w;
  logic [2:0][CB:0]   dif;
  logic [2:0][CB-1:0] ax1_nxt;
  logic [2:0][CB-1:0] ax1_r;
  logic               v1_r;

  assign pt_w = {in_point_z, in_point_y, in_point_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif[a] = {pt_w[a][CB-1], pt_w[a]} -
               {center_r[a*CB + CB - 1], center_r[a*CB +: CB]};
      ax1_nxt[a] = dif[a][CB] ? (~dif[a][CB-1:0] + CB'(1)) : dif[a][CB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares.
  // ---------------------------------------------------------------------------
  logic [2:0][2*CB-1:0] sq2_r;
  logic [2:0][CB-1:0]   ax2_r;
  logic                 v2_r;

  // ---------------------------------------------------------------------------
  // Stage 3: sums, containment test, radicand.
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]    ssph;
  logic [SQ_W-1:0]    scyl;
  logic               ins3_nxt;
  logic [SQ_W-1:0]    ssel;
  logic [RAD_W-1:0]   rad3_r;
  logic               ins3_r;
  logic [2:0][CB-1:0] ax3_r;
  logic               v3_r;

  always_comb begin
    scyl = SQ_W'(sq2_r[0]) + SQ_W'(sq2_r[1]);
    ssph = scyl + SQ_W'(sq2_r[2]);
    ssel = is_cyl ? scyl : ssph;
    case (shape_r)
      vbf_pkg::SHAPE_SPHERE: ins3_nxt = (ssph <= SQ_W'(rsq_r));
      vbf_pkg::SHAPE_BOX:    ins3_nxt = (ax2_r[0] <= ext_r[0 +: CB]) &&
                                        (ax2_r[1] <= ext_r[CB +: CB]) &&
                                        (ax2_r[2] <= ext_r[2*CB +: CB]);
      vbf_pkg::SHAPE_CYL:    ins3_nxt = (scyl <= SQ_W'(rsq_r)) &&
                                        ({ax2_r[2], 1'b0} <= {1'b0, height_r});
      default:               ins3_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= ax1_nxt;
      for (int a = 0; a < 3; a++) begin
        sq2_r[a] <= (2*CB)'(ax1_r[a]) * (2*CB)'(ax1_r[a]);
      end
      ax2_r  <= ax1_r;
      rad3_r <= {ssel, {vbf_pkg::SQRT_PAD{1'b0}}};
      ins3_r <= ins3_nxt;
      ax3_r  <= ax2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one root bit per cell. Side data rides alongside.
  // ---------------------------------------------------------------------------
  logic [RT_W+2:0]  srem [RT_W+1];
  logic [RT_W-1:0]  sroot[RT_W+1];
  logic [RAD_W-1:0] srad [RT_W+1];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad3_r;

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    vbf_sqrt_cell #(
      .RAD_W (RAD_W),
      .RT_W  (RT_W)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .rad_i  (srad[k]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1]),
      .rad_o  (srad[k+1])
    );
  end

  logic               vld_a;
  logic [3*CB:0]      side_a;
  logic               ins_a;
  logic [2:0][CB-1:0] ax_a;

  vbf_delay #(
    .W     (3*CB + 1),
    .DEPTH (RT_W)
  ) u_dly_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (v3_r),
    .dat_i ({ins3_r, ax3_r}),
    .vld_o (vld_a),
    .dat_o (side_a)
  );

  assign ins_a = side_a[3*CB];
  assign ax_a  = side_a[3*CB-1:0];

  // ---------------------------------------------------------------------------
  // Divider bank: radial, three axis ratios (z doubles as cylinder height
  // ratio) and the inner core fraction, one quotient bit per cell.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] dnum[NL];
  logic [DW-1:0] dden[NL];

  always_comb begin
    dnum[L_RAD] = sroot[RT_W];
    dden[L_RAD] = DW'({radius_r, {vbf_pkg::COORD_FRAC{1'b0}}});
    dnum[L_X]   = DW'(ax_a[0]);
    dden[L_X]   = DW'(ext_r[0 +: CB]);
    dnum[L_Y]   = DW'(ax_a[1]);
    dden[L_Y]   = DW'(ext_r[CB +: CB]);
    dnum[L_Z]   = is_cyl ? DW'({ax_a[2], 1'b0}) : DW'(ax_a[2]);
    dden[L_Z]   = is_cyl ? DW'(height_r) : DW'(ext_r[2*CB +: CB]);
    dnum[L_C]   = DW'(inner_r);
    dden[L_C]   = is_box ? DW'(maxe_r) : DW'(radius_r);
  end

  logic [DW:0]   drem[NL][QW+1];
  logic [DW-1:0] dden_c[NL][QW+1];
  logic [QW-1:0] dq  [NL][QW+1];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign drem[l][0]   = {1'b0, dnum[l]};
    assign dden_c[l][0] = dden[l];
    assign dq[l][0]     = '0;
    for (genvar k = 0; k < QW; k++) begin : g_div
      vbf_div_cell #(
        .W  (DW),
        .QW (QW)
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (drem[l][k]),
        .den_i (dden_c[l][k]),
        .q_i   (dq[l][k]),
        .rem_o (drem[l][k+1]),
        .den_o (dden_c[l][k+1]),
        .q_o   (dq[l][k+1])
      );
    end
  end

  logic vld_b;
  logic ins_b;

  vbf_delay #(
    .W     (1),
    .DEPTH (QW)
  ) u_dly_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_a),
    .dat_i (ins_a),
    .vld_o (vld_b),
    .dat_o (ins_b)
  );

  // ---------------------------------------------------------------------------
  // Combine stage: normalized distance n, clamped core fraction c.
  // A zero divisor forces its ratio to zero.
  // ---------------------------------------------------------------------------
  logic [QW-1:0] q_rad;
  logic [QW-1:0] q_x;
  logic [QW-1:0] q_y;
  logic [QW-1:0] q_z;
  logic [QW-1:0] q_box;
  logic [QW-1:0] n_nxt;
  logic [QW-1:0] c_nxt;
  logic [CB-1:0] c_den;
  logic [QW-1:0] n_r;
  logic [QW-1:0] c_r;
  logic          ins_e_r;
  logic          full_e_r;
  logic          ve_r;

  always_comb begin
    q_rad = (radius_r == '0) ? '0 : dq[L_RAD][QW];
    q_x   = (ext_r[0 +: CB] == '0) ? '0 : dq[L_X][QW];
    q_y   = (ext_r[CB +: CB] == '0) ? '0 : dq[L_Y][QW];
    if (is_cyl) begin
      q_z = (height_r == '0) ? '0 : dq[L_Z][QW];
    end else begin
      q_z = (ext_r[2*CB +: CB] == '0) ? '0 : dq[L_Z][QW];
    end
    q_box = q_x;
    if (q_y > q_box) q_box = q_y;
    if (q_z > q_box) q_box = q_z;
    case (shape_r)
      vbf_pkg::SHAPE_SPHERE: n_nxt = q_rad;
      vbf_pkg::SHAPE_BOX:    n_nxt = q_box;
      vbf_pkg::SHAPE_CYL:    n_nxt = (q_z > q_rad) ? q_z : q_rad;
      default:               n_nxt = '0;
    endcase
    // Core at or beyond the boundary saturates at full strength.
    c_den = is_box ? maxe_r : radius_r;
    if (c_den == '0) begin
      c_nxt = '0;
    end else if (inner_r >= c_den) begin
      c_nxt = ONE;
    end else begin
      c_nxt = dq[L_C][QW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= n_nxt;
      c_r      <= c_nxt;
      ins_e_r  <= ins_b;
      full_e_r <= (n_nxt <= c_nxt) || (c_nxt == ONE);
    end
  end

  // ---------------------------------------------------------------------------
  // Falloff divider: (n - c) / (1 - c).
  // ---------------------------------------------------------------------------
  logic [QW:0]   frem[QW+1];
  logic [QW-1:0] fden[QW+1];
  logic [QW-1:0] fq  [QW+1];

  assign frem[0] = {1'b0, n_r - c_r};
  assign fden[0] = ONE - c_r;
  assign fq[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_fall
    vbf_div_cell #(
      .W  (QW),
      .QW (QW)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (frem[k]),
      .den_i (fden[k]),
      .q_i   (fq[k]),
      .rem_o (frem[k+1]),
      .den_o (fden[k+1]),
      .q_o   (fq[k+1])
    );
  end

  logic [1:0] side_c;

  vbf_delay #(
    .W     (2),
    .DEPTH (QW)
  ) u_dly_fall (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (ve_r),
    .dat_i ({ins_e_r, full_e_r}),
    .vld_o (vld_c),
    .dat_o (side_c)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic          out_load;
  logic [QW-1:0] blend_nxt;
  logic          out_inside_r;
  logic [QW-1:0] out_blend_r;

  assign out_load = vld_c && en;

  always_comb begin
    if (!side_c[1]) begin
      blend_nxt = '0;
    end else if (side_c[0]) begin
      blend_nxt = ONE;
    end else begin
      blend_nxt = ONE - fq[QW];
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_inside_r <= side_c[1];
      out_blend_r  <= blend_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_blend      = out_blend_r;

endmodule

// File: hdl/vbf_checker.sv
// Port-level checker for the volume blend factor block, bound to the top level.
// Depends on volume_blend_factor_top_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "volume_blend_factor_top_defines.svh"

module vbf_checker #(
  parameter int BLEND_FRAC_BITS = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_inside_res,
  input logic [BLEND_FRAC_BITS:0] out_blend
);

  localparam logic [BLEND_FRAC_BITS:0] ONE = (BLEND_FRAC_BITS+1)'(1) << BLEND_FRAC_BITS;

  // A blocked result holds.
  `VBF_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_blend) && $stable(out_inside_res)), "result changed while stalled")
  // Outside points never carry a blend.
  `VBF_ASSERT(a_outside_zero, (out_valid && !out_inside_res) |-> (out_blend == '0), "nonzero blend outside")
  // Blend never exceeds full strength.
  `VBF_ASSERT(a_blend_range, out_valid |-> (out_blend <= ONE), "blend above one")
  // Input is held back only by a blocked output.
  `VBF_ASSERT(a_ready_cause, !in_ready |-> (out_valid && !out_ready), "input stalled without backpressure")
  // Reset empties the output.
  `VBF_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind volume_blend_factor_top vbf_checker #(
  .BLEND_FRAC_BITS (BLEND_FRAC_BITS)
) u_vbf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res),
  .out_blend      (out_blend)
);

// File: tb/volume_blend_factor_top_tb.sv
// Self-checking testbench for the volume blend factor block: sphere, box, cylinder
// and unknown-shape queries under several configurations, with random stalls on both
// channels. Depends on vbf_pkg and volume_blend_factor_top.
`timescale 1ns / 1ps

module volume_blend_factor_top_tb;

  localparam int CB = vbf_pkg::COORD_BITS_DEF;
  localparam int FB = vbf_pkg::BLEND_FRAC_BITS_DEF;
  localparam longint ONE = 64'd1 << FB;
  localparam int LATENCY = 2 * FB + CB + 16;
  localparam logic [1:0] SHAPE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
  } point_t;

  typedef struct packed {
    logic        in_vol;
    logic [FB:0] blend;
  } blend_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic [FB:0] out_blend;
  logic cfg_we = 1'b0;
  logic [vbf_pkg::CFG_IDX_W-1:0] cfg_index = vbf_pkg::REG_SHAPE;
  logic [3*CB-1:0] cfg_data = '0;

  volume_blend_factor_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [1:0]      shape_q;
  logic [3*CB-1:0] center_q, extents_q;
  logic [CB-1:0]   radius_q, height_q, inner_q;

  point_t     point_queue[$];
  blend_res_t expected_blends[$];
  int errors = 0;
  longint cycle_count = 0;
  int hold_off = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned frac_of(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return (num << FB) / den;
  endfunction

  function automatic longint unsigned radial_frac(longint unsigned ss, longint unsigned r);
    if (r == 0) return 0;
    return (isqrt(ss << 16) << FB) / (r << vbf_pkg::COORD_FRAC);
  endfunction

  // Compute inside flag and blend for one point against the shadow config.
  function automatic blend_res_t predict_blend(point_t p);
    longint unsigned ax[3], ext[3];
    longint unsigned n, c, t, ss, maxe, nz;
    logic [CB-1:0] pc[3];
    logic [CB-1:0] cc;
    longint d;
    bit ins;
    blend_res_t r;
    pc[0] = p.x; pc[1] = p.y; pc[2] = p.z;
    n = 0; c = 0; ins = 0;
    for (int i = 0; i < 3; i++) begin
      cc = center_q[i*CB +: CB];
      d = longint'(signed'(pc[i])) - longint'(signed'(cc));
      ax[i] = d < 0 ? -d : d;
      ext[i] = extents_q[i*CB +: CB];
    end
    case (shape_q)
      vbf_pkg::SHAPE_SPHERE: begin
        ss = ax[0]*ax[0] + ax[1]*ax[1] + ax[2]*ax[2];
        ins = ss <= longint'(radius_q) * radius_q;
        if (ins) begin
          n = radial_frac(ss, radius_q);
          c = frac_of(inner_q, radius_q);
        end
      end
      vbf_pkg::SHAPE_BOX: begin
        ins = ax[0] <= ext[0] && ax[1] <= ext[1] && ax[2] <= ext[2];
        if (ins) begin
          for (int i = 0; i < 3; i++) begin
            t = frac_of(ax[i], ext[i]);
            if (t > n) n = t;
          end
          maxe = ext[0];
          if (ext[1] > maxe) maxe = ext[1];
          if (ext[2] > maxe) maxe = ext[2];
          c = frac_of(inner_q, maxe);
        end
      end
      vbf_pkg::SHAPE_CYL: begin
        ss = ax[0]*ax[0] + ax[1]*ax[1];
        ins = ss <= longint'(radius_q) * radius_q && 2 * ax[2] <= height_q;
        if (ins) begin
          nz = frac_of(2 * ax[2], height_q);
          n = radial_frac(ss, radius_q);
          if (nz > n) n = nz;
          c = frac_of(inner_q, radius_q);
        end
      end
      default: ins = 0;
    endcase
    r.in_vol = ins;
    r.blend = '0;
    if (ins) begin
      if (c > ONE) c = ONE;
      if (n <= c || c == ONE) begin
        r.blend = (FB+1)'(ONE);
      end else begin
        t = ((n - c) << FB) / (ONE - c);
        if (t > ONE) t = ONE;
        r.blend = (FB+1)'(ONE - t);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  // Append one point to the pending request list.
  task automatic add_point(point_t p);
    point_queue.insert(point_queue.size(), p);
  endtask

  // Driver: present requests from the queue with random gaps.
  int in_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_blends.insert(expected_blends.size(),
                               predict_blend({in_point_x, in_point_y, in_point_z}));
        void'(point_queue.pop_front());
        in_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (in_valid && !in_ready) begin
        // hold the request steady
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_point_x <= point_queue[0].x;
        in_point_y <= point_queue[0].y;
        in_point_z <= point_queue[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result, stall out_ready at random.
  int out_gap = 0;
  blend_res_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_blends.size() == 0) begin
          report_mismatch("unexpected result, inside", out_inside_res, 0);
        end else begin
          want = expected_blends.pop_front();
          if (out_inside_res !== want.in_vol)
            report_mismatch("inside", out_inside_res, want.in_vol);
          if (out_blend !== want.blend)
            report_mismatch("blend", out_blend, want.blend);
        end
        out_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [vbf_pkg::CFG_IDX_W-1:0] idx, logic [3*CB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      vbf_pkg::REG_SHAPE:  shape_q   = val[1:0];
      vbf_pkg::REG_CENTER: center_q  = val;
      vbf_pkg::REG_RADIUS: radius_q  = val[CB-1:0];
      vbf_pkg::REG_EXT:    extents_q = val;
      vbf_pkg::REG_HEIGHT: height_q  = val[CB-1:0];
      vbf_pkg::REG_INNER:  inner_q   = val[CB-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request sent so far has come back.
  task automatic drain_pipe();
    while (point_queue.size() > 0 || in_valid || expected_blends.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      default: return CB'($urandom);
    endcase
  endfunction

  // Point near the configured center so most requests land inside.
  function automatic point_t near_point(int span);
    point_t p;
    p.x = CB'(int'(center_q[0 +: CB]) + int'($urandom_range(0, 2*span)) - span);
    p.y = CB'(int'(center_q[CB +: CB]) + int'($urandom_range(0, 2*span)) - span);
    p.z = CB'(int'(center_q[2*CB +: CB]) + int'($urandom_range(0, 2*span)) - span);
    return p;
  endfunction

  task automatic run_phase(logic [1:0] shp, logic [3*CB-1:0] ctr, logic [CB-1:0] rad,
                           logic [3*CB-1:0] ext, logic [CB-1:0] hgt, logic [CB-1:0] inr,
                           int count, int span);
    write_reg(vbf_pkg::REG_SHAPE, (3*CB)'(shp));
    write_reg(vbf_pkg::REG_CENTER, ctr);
    write_reg(vbf_pkg::REG_RADIUS, (3*CB)'(rad));
    write_reg(vbf_pkg::REG_EXT, ext);
    write_reg(vbf_pkg::REG_HEIGHT, (3*CB)'(hgt));
    write_reg(vbf_pkg::REG_INNER, (3*CB)'(inr));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_point({rand_coord(), rand_coord(), rand_coord()});
      else
        add_point(near_point(span));
    end
    drain_pipe();
  endtask

  initial begin
    shape_q = '0; center_q = '0; extents_q = '0;
    radius_q = '0; height_q = '0; inner_q = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero config, field extremes, center on point.
    add_point({20'h00000, 20'h00000, 20'h00000});
    add_point({20'h7FFFF, 20'h80000, 20'h7FFFF});
    add_point({20'h80000, 20'h7FFFF, 20'h80000});
    drain_pipe();
    // Sphere on the boundary, at center, inner core covering all.
    write_reg(vbf_pkg::REG_RADIUS, (3*CB)'(20'd256));
    write_reg(vbf_pkg::REG_INNER, (3*CB)'(20'd128));
    add_point({20'd256, 20'd0, 20'd0});
    add_point({20'd257, 20'd0, 20'd0});
    add_point({20'd0, 20'd0, 20'd0});
    add_point({20'd200, 20'd0, 20'd0});
    drain_pipe();
    write_reg(vbf_pkg::REG_INNER, (3*CB)'(20'hFFFFF));
    add_point({20'd200, 20'd10, 20'd0});
    drain_pipe();
    // Box with one zero extent; cylinder with zero height; unknown shape.
    write_reg(vbf_pkg::REG_SHAPE, (3*CB)'(vbf_pkg::SHAPE_BOX));
    write_reg(vbf_pkg::REG_EXT, {20'd0, 20'd512, 20'd100});
    write_reg(vbf_pkg::REG_INNER, (3*CB)'(20'd0));
    add_point({20'd0, 20'd300, 20'd50});
    add_point({20'd0, 20'hFFE00, 20'hFFF9C});
    add_point({20'd1, 20'd0, 20'd0});
    drain_pipe();
    write_reg(vbf_pkg::REG_SHAPE, (3*CB)'(vbf_pkg::SHAPE_CYL));
    add_point({20'd0, 20'd10, 20'd10});
    add_point({20'd1, 20'd10, 20'd10});
    drain_pipe();
    write_reg(vbf_pkg::REG_SHAPE, (3*CB)'(SHAPE_UNKNOWN));
    add_point({20'd0, 20'd0, 20'd0});
    drain_pipe();

    // Long receiver stall while requests keep coming, to fill the pipe.
    hold_off = 3 * LATENCY;
    run_phase(vbf_pkg::SHAPE_SPHERE, '0, 20'd4000, '0, '0, 20'd1000, 150, 4500);
    run_phase(vbf_pkg::SHAPE_BOX, {20'hFF000, 20'd3000, 20'h80000}, 20'd0,
              {20'd2000, 20'd500, 20'd7000}, 20'd0, 20'd300, 150, 7500);
    run_phase(vbf_pkg::SHAPE_CYL, {20'd100, 20'hFFF00, 20'd5}, 20'd6000, '0, 20'd9000,
              20'd0, 150, 7000);
    run_phase(vbf_pkg::SHAPE_SPHERE, {20'h7FFFF, 20'h80000, 20'h12345}, 20'hFFFFF, '0, '0,
              20'hFFFFF, 120, 300000);
    run_phase(vbf_pkg::SHAPE_BOX, (3*CB)'({$urandom, $urandom}), 20'd0,
              {20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 20'hFFFFF, 20'h7FFFF, 120, 524287);
    run_phase(vbf_pkg::SHAPE_CYL, '0, 20'hFFFFF, '0, 20'hFFFFF, 20'h40000, 120, 524287);
    run_phase(SHAPE_UNKNOWN, (3*CB)'({$urandom, $urandom}), CB'($urandom),
              (3*CB)'({$urandom, $urandom}), CB'($urandom), CB'($urandom), 40, 1000);
    run_phase(vbf_pkg::SHAPE_SPHERE, {20'd0, 20'd0, CB'($urandom_range(0, 1000))},
              CB'($urandom_range(1, 3000)), '0, '0, CB'($urandom_range(0, 3000)),
              100, 3000);
    run_phase(vbf_pkg::SHAPE_CYL, (3*CB)'({$urandom, $urandom}),
              CB'($urandom_range(0, 2000)), '0, CB'($urandom_range(0, 4000)),
              CB'($urandom_range(0, 2000)), 100, 2500);

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_blends.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
